@@ rtl/skst_pkg.sv @@
// shared types and constants of the sorted key set table
// used by skst_key_ram, skst_ctrl and sorted_key_set_table_core
package skst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 256;
    localparam int WORD_W      = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int OUT_W       = 5;

    typedef logic [1:0]       kind_t;
    typedef logic [2:0]       status_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;

    localparam status_t STATUS_OK     = 3'd0;
    localparam status_t STATUS_ZERO   = 3'd1;
    localparam status_t STATUS_DUP    = 3'd2;
    localparam status_t STATUS_FULL   = 3'd3;
    localparam status_t STATUS_ABSENT = 3'd4;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] entry_total;
    } result_t;

    typedef struct packed {
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        key_t wr_data;
    } ram_req_t;

endpackage

@@ rtl/skst_key_ram.sv @@
// key store: one write port, one registered read port
// depends on skst_pkg
module skst_key_ram (
    input  logic              aclk,
    input  skst_pkg::ram_req_t ram_req,
    output skst_pkg::key_t    rdata
);
    import skst_pkg::*;

    key_t mem [MAX_ENTRIES];
    key_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
        rdata_reg <= mem[ram_req.rd_addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/skst_ctrl.sv @@
// sequencer: linear search, shift up / insert, shift down, result
// depends on skst_pkg, drives skst_key_ram
module skst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  skst_pkg::kind_t    req_kind,
    input  skst_pkg::key_t     req_key,
    output logic               res_valid,
    input  logic               res_ready,
    output skst_pkg::result_t  res,
    output skst_pkg::ram_req_t ram_req,
    input  skst_pkg::key_t     ram_rdata
);
    import skst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_UP     = 6'b000100,
        S_INS    = 6'b001000,
        S_DN     = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    key_t       key_reg, key_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sh_reg, sh_next;
    idx_t       wr_addr_reg, wr_addr_next;
    logic       wr_pend_reg, wr_pend_next;
    logic       hit_reg, hit_next;
    status_t    status_reg, status_next;

    logic entry_lt;
    logic entry_eq;
    logic at_end;
    logic hit_now;
    logic key_zero;

    assign entry_lt = ram_rdata < key_reg;
    assign entry_eq = ram_rdata == key_reg;
    assign at_end   = pos_reg == count_reg;
    assign hit_now  = !at_end && entry_eq;
    assign key_zero = key_reg == '0;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        sh_next         = sh_reg;
        wr_addr_next    = wr_addr_reg;
        wr_pend_next    = wr_pend_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        ram_req.rd_addr = '0;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wr_addr_reg;
        ram_req.wr_data = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    kind_next  = req_kind;
                    key_next   = req_key;
                    pos_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                ram_req.rd_addr = idx_t'(pos_reg);
                if (at_end || !entry_lt) begin
                    hit_next     = hit_now;
                    wr_pend_next = 1'b0;
                    state_next   = S_DONE;
                    if (kind_reg == KIND_ADD) begin
                        if (key_zero) begin
                            status_next = STATUS_ZERO;
                        end else if (hit_now) begin
                            status_next = STATUS_DUP;
                        end else if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                            status_next = STATUS_FULL;
                        end else begin
                            status_next = STATUS_OK;
                            sh_next     = count_reg;
                            state_next  = S_UP;
                        end
                    end else if (kind_reg == KIND_REMOVE) begin
                        if (!hit_now) begin
                            status_next = STATUS_ABSENT;
                        end else begin
                            status_next = STATUS_OK;
                            sh_next     = pos_reg + CNT_W'(1);
                            state_next  = S_DN;
                        end
                    end else begin
                        status_next = hit_now ? STATUS_OK : STATUS_ABSENT;
                    end
                end else begin
                    pos_next        = pos_reg + CNT_W'(1);
                    ram_req.rd_addr = idx_t'(pos_reg + CNT_W'(1));
                end
            end
            S_UP: begin
                ram_req.wr_en = wr_pend_reg;
                if (sh_reg != pos_reg) begin
                    ram_req.rd_addr = idx_t'(sh_reg - CNT_W'(1));
                    wr_addr_next    = idx_t'(sh_reg);
                    wr_pend_next    = 1'b1;
                    sh_next         = sh_reg - CNT_W'(1);
                end else begin
                    wr_pend_next = 1'b0;
                    state_next   = S_INS;
                end
            end
            S_INS: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_t'(pos_reg);
                ram_req.wr_data = key_reg;
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_DONE;
            end
            S_DN: begin
                ram_req.wr_en = wr_pend_reg;
                if (sh_reg < count_reg) begin
                    ram_req.rd_addr = idx_t'(sh_reg);
                    wr_addr_next    = idx_t'(sh_reg - CNT_W'(1));
                    wr_pend_next    = 1'b1;
                    sh_next         = sh_reg + CNT_W'(1);
                end else begin
                    wr_pend_next = 1'b0;
                    count_next   = count_reg - CNT_W'(1);
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        sh_reg      <= sh_next;
        wr_addr_reg <= wr_addr_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
    end

    assign res.status      = status_reg;
    assign res.found       = hit_reg;
    assign res.position    = OUT_W'(pos_reg);
    assign res.entry_total = OUT_W'(count_reg);

endmodule

@@ rtl/sorted_key_set_table_core.sv @@
// top level of the sorted key set table: request/result channels and output register
// depends on skst_pkg, skst_ctrl and skst_key_ram
//
//  channel  | ports                      | contents
//  ---------+----------------------------+------------------------------------------
//  request  | s_tvalid s_tready s_tdata  | tuser: kind; tdata: key_word0..key_word3
//           | s_tuser                    |
//  result   | m_tvalid m_tready m_tdata  | tdata: status, found, position, entry_total
//
// a request runs a linear search reading one stored key per cycle from the
// key memory, then for an add or remove a shift that moves the entries behind
// the position one by one, plus the insert and result states
// reset clears the entry count; stored keys past the count are never used
// a result waits in the output register while the next request is taken
module sorted_key_set_table_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // key_word0, key_word1, key_word2, key_word3
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // status, found, position, entry_total, zero pad
);
    import skst_pkg::*;

    key_t     req_key;
    key_t     ram_rdata;
    ram_req_t ram_req;
    result_t  res;
    logic     res_valid;
    logic     res_ready;
    logic     m_valid_reg;
    logic [15:0] m_data_reg;

    // word0 is most significant for ordering
    assign req_key = {s_tdata[WORD_W-1:0], s_tdata[2*WORD_W-1:WORD_W],
                      s_tdata[3*WORD_W-1:2*WORD_W], s_tdata[4*WORD_W-1:3*WORD_W]};

    skst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_kind  (s_tuser),
        .req_key   (req_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    skst_key_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= {2'b00, res.entry_total, res.position, res.found, res.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for sorted_key_set_table_core: directed table, then random add/remove/lookup
// depends on skst_pkg and the rtl of sorted_key_set_table_core; reads no files
module testbench;
    import skst_pkg::*;

    localparam kind_t KIND_LOOKUP     = 2'd2;
    localparam kind_t KIND_LOOKUP_ALT = 2'd3;
    localparam int RANDOM_ITEMS = 925;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_AT     = 600;
    localparam int LONG_HOLD    = 200;
    localparam int POOL_N       = 24;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_LIMIT  = 50;
    localparam logic [255:0] KEY_ZERO = '0;
    localparam logic [255:0] KEY_ONE  = 256'd1;
    localparam logic [255:0] KEY_MAX  = '1;

    typedef struct {
        bit      pinned;
        result_t value;
    } pin_t;

    typedef struct {
        kind_t        kind;
        logic [255:0] key;
        bit           pinned;
        result_t      want;
    } step_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;

    // predictor state: keys held as {word0, word1, word2, word3} so plain compare gives the order
    logic [255:0] table_keys [MAX_ENTRIES];
    int unsigned  table_count = 0;

    result_t      pending_results [$];
    pin_t         pinned_results [$];
    logic [255:0] key_pool [POOL_N];
    int unsigned  mismatch_count = 0;
    int unsigned  result_index = 0;
    int unsigned  cycle_count = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    sorted_key_set_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bus order has word0 in the low bits, the ordered form has it on top
    function automatic logic [255:0] swap_words(logic [255:0] v);
        return {v[63:0], v[127:64], v[191:128], v[255:192]};
    endfunction

    function automatic result_t apply_key_op(kind_t kind, logic [255:0] key);
        result_t     r;
        int unsigned pos;
        logic        hit;
        pos = 0;
        while (pos < table_count && table_keys[pos] < key)
            pos++;
        hit = (pos < table_count) && (table_keys[pos] == key);
        r.found = hit;
        r.position = 5'(pos);
        if (kind == KIND_ADD) begin
            if (key == KEY_ZERO) begin
                r.status = STATUS_ZERO;
            end else if (hit) begin
                r.status = STATUS_DUP;
            end else if (table_count >= MAX_ENTRIES) begin
                r.status = STATUS_FULL;
            end else begin
                for (int i = table_count; i > pos; i--)
                    table_keys[i] = table_keys[i-1];
                table_keys[pos] = key;
                table_count++;
                r.status = STATUS_OK;
            end
        end else if (kind == KIND_REMOVE) begin
            if (!hit) begin
                r.status = STATUS_ABSENT;
            end else begin
                for (int i = pos; i + 1 < table_count; i++)
                    table_keys[i] = table_keys[i+1];
                table_count--;
                table_keys[table_count] = KEY_ZERO;
                r.status = STATUS_OK;
            end
        end else begin
            r.status = hit ? STATUS_OK : STATUS_ABSENT;
        end
        r.entry_total = 5'(table_count);
        return r;
    endfunction

    function automatic logic [255:0] make_key();
        logic [63:0] w [4];
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
                0: w[i] = '0;
                1: w[i] = '1;
                2: w[i] = 64'($urandom_range(0, 3));
                default: w[i] = {$urandom, $urandom};
            endcase
        end
        return {w[0], w[1], w[2], w[3]};
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("result %0d %s: got %0d, want %0d", result_index, what, got, want);
    endtask

    task automatic send_request(kind_t kind, logic [255:0] key, bit pinned, result_t want);
        pinned_results.push_back(pin_t'{pinned, want});
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= swap_words(key);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // request side: predict every accepted request
    always @(posedge aclk) begin
        pin_t    pin;
        result_t predicted;
        if (aresetn && s_tvalid && s_tready) begin
            predicted = apply_key_op(s_tuser, swap_words(s_tdata));
            pin = pinned_results.pop_front();
            pending_results.push_back(pin.pinned ? pin.value : predicted);
        end
    end

    // result side
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
                if (m_tdata[3] != want.found)
                    report_mismatch("found", 32'(m_tdata[3]), 32'(want.found));
                if (m_tdata[8:4] != want.position)
                    report_mismatch("position", 32'(m_tdata[8:4]), 32'(want.position));
                if (m_tdata[13:9] != want.entry_total)
                    report_mismatch("entry_total", 32'(m_tdata[13:9]),
                                    32'(want.entry_total));
            end
            result_index++;
        end
    end

    // receiver stalls, plus one long hold-off to back up the request side
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_key_set_table_core: mismatch");
            $finish;
        end
    end

    initial begin
        step_row_t    plan [$];
        logic [255:0] key;
        kind_t        kind;
        int unsigned  pick;
        bit           filling;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_ADD;

        plan.push_back(step_row_t'{KIND_LOOKUP, KEY_ONE, 1'b1,
                                   result_t'{STATUS_ABSENT, 1'b0, 5'd0, 5'd0}});
        plan.push_back(step_row_t'{KIND_REMOVE, KEY_MAX, 1'b1,
                                   result_t'{STATUS_ABSENT, 1'b0, 5'd0, 5'd0}});
        plan.push_back(step_row_t'{KIND_ADD, KEY_ZERO, 1'b1,
                                   result_t'{STATUS_ZERO, 1'b0, 5'd0, 5'd0}});
        plan.push_back(step_row_t'{KIND_ADD, KEY_MAX, 1'b1,
                                   result_t'{STATUS_OK, 1'b0, 5'd0, 5'd1}});
        plan.push_back(step_row_t'{KIND_ADD, KEY_ONE, 1'b1,
                                   result_t'{STATUS_OK, 1'b0, 5'd0, 5'd2}});
        plan.push_back(step_row_t'{KIND_ADD, KEY_MAX, 1'b1,
                                   result_t'{STATUS_DUP, 1'b1, 5'd1, 5'd2}});
        plan.push_back(step_row_t'{KIND_LOOKUP_ALT, KEY_ONE, 1'b1,
                                   result_t'{STATUS_OK, 1'b1, 5'd0, 5'd2}});
        plan.push_back(step_row_t'{KIND_REMOVE, KEY_MAX, 1'b1,
                                   result_t'{STATUS_OK, 1'b1, 5'd1, 5'd1}});
        plan.push_back(step_row_t'{KIND_REMOVE, KEY_MAX, 1'b1,
                                   result_t'{STATUS_ABSENT, 1'b0, 5'd1, 5'd1}});
        // fill in descending order so every insert after the first shifts; groups share word0
        for (int i = 14; i >= 0; i--)
            plan.push_back(step_row_t'{KIND_ADD,
                                       {64'(i / 4), 64'd0, 64'(i % 4 / 2), 64'(i % 4 + 2)},
                                       1'b0, result_t'('0)});
        plan.push_back(step_row_t'{KIND_ADD, KEY_MAX, 1'b1,
                                   result_t'{STATUS_FULL, 1'b0, 5'd16, 5'd16}});

        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = make_key();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            sender_gap();
            send_request(plan[i].kind, plan[i].key, plan[i].pinned, plan[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == DRAIN_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0)
                    @(posedge aclk);
            end
            if ($urandom_range(0, 19) == 0)
                key_pool[$urandom_range(0, POOL_N - 1)] = make_key();

            // alternate between filling the table and draining it
            filling = ((n / 80) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < (filling ? 65 : 20))
                kind = KIND_ADD;
            else if (pick < (filling ? 85 : 80))
                kind = KIND_REMOVE;
            else
                kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_LOOKUP_ALT;

            pick = $urandom_range(0, 99);
            if (pick < 85)
                key = key_pool[$urandom_range(0, POOL_N - 1)];
            else if (pick < 95)
                key = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
            else
                key = KEY_ZERO;

            sender_gap();
            send_request(kind, key, 1'b0, result_t'('0));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("sorted_key_set_table_core: match");
        else
            $display("sorted_key_set_table_core: mismatch");
        $finish;
    end

endmodule
